FILE: rtl/url_td_pkg.sv
// ---------------------------------------------------------------------------
// url_td_pkg
// Types, result codes and helpers shared by the request target decoder.
// ---------------------------------------------------------------------------
package url_td_pkg;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] decoded_byte;
    logic       key_empty;
    logic       bad_target;
    logic       run_end;
  } out_item_t;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
    out_item_t  res2;
  } bundle_t;

  localparam logic [2:0] KIND_PATH       = 3'd0;
  localparam logic [2:0] KIND_KEY        = 3'd1;
  localparam logic [2:0] KIND_VALUE      = 3'd2;
  localparam logic [2:0] KIND_PAIR_END   = 3'd3;
  localparam logic [2:0] KIND_TARGET_END = 3'd4;

  localparam logic [1:0] REG_PATH  = 2'd0;
  localparam logic [1:0] REG_KEY   = 2'd1;
  localparam logic [1:0] REG_VALUE = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/url_target_decoder.sv
// ---------------------------------------------------------------------------
// url_target_decoder
// Streaming percent-decoder and query splitter for an HTTP request target.
// ---------------------------------------------------------------------------
// Input channel target_*: one encoded byte per beat, is_final on the last
// byte of a target. Output channel result_*: decoded path/key/value bytes,
// pair-end markers and one target-end marker per target, run_end on the
// last result caused by an input beat.
// Each accepted byte is decoded in the accept cycle into a bundle of zero to
// three results held in a result register; results appear in the cycle
// after the byte is taken. While result_stall is low the result register
// drains one result per cycle, and plain bytes, giving at most one result,
// stream at one per cycle; a byte giving two or three results holds the
// input while the bundle drains. A byte with no result puts nothing on the
// output.
// When result_stall is high the held result stays put, and target_stall
// rises as soon as the result register cannot take the next bundle.
// Reset (rst, synchronous) drops any held results and returns the parser to
// the start of a path.
// ---------------------------------------------------------------------------
module url_target_decoder
  import url_td_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      target_valid,
  output logic      target_stall,
  input  in_item_t  target_beat,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_beat
);

  bundle_t    bundle;
  logic       fire;
  logic       take;
  logic       last;
  logic       held;
  logic [1:0] count;
  logic [1:0] idx;
  out_item_t  res [MAX_RES];

  url_td_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (target_beat),
    .bundle (bundle)
  );

  assign take         = held && !result_stall;
  assign last         = (idx == count - 2'd1);
  assign target_stall = held && !(take && last);
  assign fire         = target_valid && !target_stall;
  assign result_valid = held;

  always_comb begin
    case (idx)
      2'd0:    result_beat = res[0];
      2'd1:    result_beat = res[1];
      default: result_beat = res[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (take) begin
        if (last) held <= 1'b0;
        else idx <= idx + 2'd1;
      end
      if (fire && bundle.count != 2'd0) begin
        held <= 1'b1;
        idx  <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && bundle.count != 2'd0) begin
      count  <= bundle.count;
      res[0] <= bundle.res0;
      res[1] <= bundle.res1;
      res[2] <= bundle.res2;
    end
  end

endmodule

FILE: rtl/url_td_core.sv
// ---------------------------------------------------------------------------
// url_td_core
// Parser state and per-byte decode; yields the result bundle of one beat.
// ---------------------------------------------------------------------------
module url_td_core
  import url_td_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  output bundle_t  bundle
);

  logic [1:0] region, region_next;
  logic [1:0] esc, esc_next;
  logic [3:0] hi, hi_next;
  logic       first, first_next;
  logic       pair_has, pair_has_next;
  logic       key_has, key_has_next;
  logic       disc, disc_next;

  always_comb begin
    logic [7:0] b;
    logic [4:0] h;
    logic       err;
    logic       dv;
    logic [7:0] dbyte;
    logic       pe;
    logic       pe_empty;
    logic [1:0] n;
    out_item_t  r [MAX_RES];

    b             = item.raw_byte;
    h             = hex_digit(b);
    err           = 1'b0;
    dv            = 1'b0;
    dbyte         = 8'd0;
    pe            = 1'b0;
    pe_empty      = 1'b0;
    region_next   = region;
    esc_next      = esc;
    hi_next       = hi;
    first_next    = first;
    pair_has_next = pair_has;
    key_has_next  = key_has;
    disc_next     = disc;

    if (!disc) begin
      if (first) begin
        first_next = 1'b0;
        if (b != CH_SLASH) err = 1'b1;
      end
      if (!err) begin
        if (region != REG_PATH && !(esc == ESC_NONE && b == CH_AMP)) pair_has_next = 1'b1;
        if (esc == ESC_HIGH) begin
          if (!h[4]) err = 1'b1;
          else begin
            hi_next  = h[3:0];
            esc_next = ESC_LOW;
          end
        end else if (esc == ESC_LOW) begin
          if (!h[4]) err = 1'b1;
          else begin
            dv       = 1'b1;
            dbyte    = {hi, h[3:0]};
            esc_next = ESC_NONE;
          end
        end else if (b == CH_PERCENT) begin
          esc_next = ESC_HIGH;
        end else if (region == REG_PATH && b == CH_QUERY) begin
          region_next   = REG_KEY;
          pair_has_next = 1'b0;
          key_has_next  = 1'b0;
        end else if (region != REG_PATH && b == CH_AMP) begin
          if (pair_has) begin
            pe       = 1'b1;
            pe_empty = !key_has;
          end
          pair_has_next = 1'b0;
          key_has_next  = 1'b0;
          region_next   = REG_KEY;
        end else if (region == REG_KEY && b == CH_EQUALS) begin
          region_next = REG_VALUE;
        end else begin
          dv    = 1'b1;
          dbyte = (b == CH_PLUS) ? CH_SPACE : b;
        end
        if (dv && region == REG_KEY) key_has_next = 1'b1;
      end
      if (err) disc_next = 1'b1;
      if (item.is_final && !disc_next) begin
        if (esc_next != ESC_NONE) disc_next = 1'b1;
        else if (region_next != REG_PATH && pair_has_next) begin
          pe       = 1'b1;
          pe_empty = !key_has_next;
        end
      end
    end

    for (int i = 0; i < MAX_RES; i++) r[i] = '0;
    n = 2'd0;
    if (dv) begin
      r[n].kind         = {1'b0, region};
      r[n].decoded_byte = dbyte;
      n                 = n + 2'd1;
    end
    if (pe) begin
      r[n].kind      = KIND_PAIR_END;
      r[n].key_empty = pe_empty;
      n              = n + 2'd1;
    end
    if (item.is_final) begin
      r[n].kind       = KIND_TARGET_END;
      r[n].bad_target = disc_next;
      n               = n + 2'd1;
    end
    if (n != 2'd0) r[n - 2'd1].run_end = 1'b1;

    bundle.count = n;
    bundle.res0  = r[0];
    bundle.res1  = r[1];
    bundle.res2  = r[2];

    if (item.is_final) begin
      region_next   = REG_PATH;
      esc_next      = ESC_NONE;
      hi_next       = 4'd0;
      first_next    = 1'b1;
      pair_has_next = 1'b0;
      key_has_next  = 1'b0;
      disc_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region   <= REG_PATH;
      esc      <= ESC_NONE;
      hi       <= 4'd0;
      first    <= 1'b1;
      pair_has <= 1'b0;
      key_has  <= 1'b0;
      disc     <= 1'b0;
    end else if (fire) begin
      region   <= region_next;
      esc      <= esc_next;
      hi       <= hi_next;
      first    <= first_next;
      pair_has <= pair_has_next;
      key_has  <= key_has_next;
      disc     <= disc_next;
    end
  end

endmodule
